// ===== hw/rtl/tga_dec_pkg.sv =====
// Shared types and constants for the TGA stream decoder.
`timescale 1ns / 1ps
package tga_dec_pkg;

  typedef enum logic [1:0] {
    KIND_HEADER = 2'd0,
    KIND_PIXEL  = 2'd1,
    KIND_ERROR  = 2'd2
  } kind_e;

  typedef enum logic [2:0] {
    ERR_CMAP  = 3'd0,
    ERR_TYPE  = 3'd1,
    ERR_DEPTH = 3'd2,
    ERR_ALPHA = 3'd3,
    ERR_TRUNC = 3'd4
  } err_e;

  typedef enum logic [1:0] {
    FMT_GREY = 2'd0,
    FMT_RGB  = 2'd1,
    FMT_RGBA = 2'd2
  } fmt_e;

  typedef struct packed {
    kind_e       kind;
    logic [31:0] pixel_value;
    logic [7:0]  repeat_count;
    logic [15:0] image_width;
    logic [15:0] image_height;
    logic [5:0]  pixel_bits;
    fmt_e        image_format;
    logic [3:0]  alpha_bits;
    err_e        error_code;
    logic        last;
  } result_t;

  typedef struct packed {
    logic    push0;
    logic    push1;
    result_t res0;
    result_t res1;
  } push_t;

  localparam int OUTQ_DEPTH = 4;
  localparam int OUTQ_PTR_W = $clog2(OUTQ_DEPTH);
  localparam int OUTQ_CNT_W = $clog2(OUTQ_DEPTH + 1);

endpackage

// ===== hw/rtl/tga_dec_if.sv =====
// Byte input and result output channel interfaces.
`timescale 1ns / 1ps
interface tga_dec_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       file_start;
  logic       file_end;

  modport source (output valid, data_byte, file_start, file_end, input ready);
  modport sink (input valid, data_byte, file_start, file_end, output ready);
endinterface

interface tga_dec_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  kind;
  logic [31:0] pixel_value;
  logic [7:0]  repeat_count;
  logic [15:0] image_width;
  logic [15:0] image_height;
  logic [5:0]  pixel_bits;
  logic [1:0]  image_format;
  logic [3:0]  alpha_bits;
  logic [2:0]  error_code;
  logic        last;

  modport source (
    output valid, kind, pixel_value, repeat_count, image_width, image_height,
           pixel_bits, image_format, alpha_bits, error_code, last,
    input  ready
  );
  modport sink (
    input  valid, kind, pixel_value, repeat_count, image_width, image_height,
           pixel_bits, image_format, alpha_bits, error_code, last,
    output ready
  );
endinterface

// ===== hw/rtl/tga_dec_parser.sv =====
// Header parser and pixel packet decoder, one file byte per beat.
`timescale 1ns / 1ps
module tga_dec_parser (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                accept_i,
  input  logic [7:0]          data_byte_i,
  input  logic                file_start_i,
  input  logic                file_end_i,
  output tga_dec_pkg::push_t  push_o
);

  localparam logic [2:0] PH_HEADER = 3'd0;
  localparam logic [2:0] PH_SKIP   = 3'd1;
  localparam logic [2:0] PH_PACKET = 3'd2;
  localparam logic [2:0] PH_PIXEL  = 3'd3;
  localparam logic [2:0] PH_IDLE   = 3'd4;

  localparam logic [4:0] OFF_ID_LEN  = 5'd0;
  localparam logic [4:0] OFF_CMAP    = 5'd1;
  localparam logic [4:0] OFF_TYPE    = 5'd2;
  localparam logic [4:0] OFF_WIDTH_L = 5'd12;
  localparam logic [4:0] OFF_WIDTH_H = 5'd13;
  localparam logic [4:0] OFF_HEIGHT_L = 5'd14;
  localparam logic [4:0] OFF_HEIGHT_H = 5'd15;
  localparam logic [4:0] OFF_DEPTH   = 5'd16;
  localparam logic [4:0] OFF_DESC    = 5'd17;

  localparam logic [7:0] TYPE_TRUE     = 8'd2;
  localparam logic [7:0] TYPE_GREY     = 8'd3;
  localparam logic [7:0] TYPE_RLE_TRUE = 8'd10;
  localparam logic [7:0] TYPE_RLE_GREY = 8'd11;

  logic [2:0]  phase_q, phase_d, cur_phase;
  logic [4:0]  off_q, off_d, cur_off;
  logic [7:0]  id_left_q, id_left_d, cur_id_left;
  logic [15:0] width_q, width_d, cur_width;
  logic [15:0] height_q, height_d, cur_height;
  logic [5:0]  depth_q, depth_d, cur_depth;
  logic        rle_q, rle_d, cur_rle;
  logic        true_q, true_d, cur_true;
  logic [31:0] pix_left_q, pix_left_d, cur_pix_left;
  logic [7:0]  pkt_left_q, pkt_left_d, cur_pkt_left;
  logic        pkt_run_q, pkt_run_d, cur_pkt_run;
  logic [31:0] asm_q, asm_d, cur_asm;
  logic [1:0]  bip_q, bip_d, cur_bip;

  logic [31:0] area;
  logic [31:0] asm_new;
  logic [31:0] pix_val;
  logic [31:0] rep;
  logic [31:0] pix_rem;
  logic [2:0]  nbytes;
  logic [2:0]  bip_inc;
  logic [7:0]  pkt_cnt;
  logic [7:0]  pkt_next;
  tga_dec_pkg::push_t push;

  function automatic tga_dec_pkg::result_t err_res(input tga_dec_pkg::err_e code);
    tga_dec_pkg::result_t r;
    r            = '0;
    r.kind       = tga_dec_pkg::KIND_ERROR;
    r.error_code = code;
    r.last       = 1'b1;
    return r;
  endfunction

  assign area    = 32'(cur_width) * 32'(cur_height);
  assign asm_new = cur_asm | (32'(data_byte_i) << {cur_bip, 3'b000});
  assign nbytes  = cur_depth[5:3];
  assign bip_inc = {1'b0, cur_bip} + 3'd1;

  always_comb begin
    cur_phase    = file_start_i ? PH_HEADER : phase_q;
    cur_off      = file_start_i ? '0 : off_q;
    cur_id_left  = file_start_i ? '0 : id_left_q;
    cur_width    = file_start_i ? '0 : width_q;
    cur_height   = file_start_i ? '0 : height_q;
    cur_depth    = file_start_i ? '0 : depth_q;
    cur_rle      = file_start_i ? 1'b0 : rle_q;
    cur_true     = file_start_i ? 1'b0 : true_q;
    cur_pix_left = file_start_i ? '0 : pix_left_q;
    cur_pkt_left = file_start_i ? '0 : pkt_left_q;
    cur_pkt_run  = file_start_i ? 1'b0 : pkt_run_q;
    cur_asm      = file_start_i ? '0 : asm_q;
    cur_bip      = file_start_i ? '0 : bip_q;
  end

  always_comb begin
    phase_d    = cur_phase;
    off_d      = cur_off;
    id_left_d  = cur_id_left;
    width_d    = cur_width;
    height_d   = cur_height;
    depth_d    = cur_depth;
    rle_d      = cur_rle;
    true_d     = cur_true;
    pix_left_d = cur_pix_left;
    pkt_left_d = cur_pkt_left;
    pkt_run_d  = cur_pkt_run;
    asm_d      = cur_asm;
    bip_d      = cur_bip;
    push       = '0;
    pix_val    = asm_new;
    rep        = 32'd1;
    pix_rem    = cur_pix_left;
    pkt_cnt    = 8'({1'b0, data_byte_i[6:0]} + 8'd1);
    pkt_next   = cur_pkt_left;

    case (cur_phase)
      PH_HEADER: begin
        off_d = cur_off + 5'd1;
        case (cur_off)
          OFF_ID_LEN: id_left_d = data_byte_i;
          OFF_CMAP: begin
            if (data_byte_i == 8'd1) begin
              push.push0 = 1'b1;
              push.res0  = err_res(tga_dec_pkg::ERR_CMAP);
              phase_d    = PH_IDLE;
            end
          end
          OFF_TYPE: begin
            case (data_byte_i)
              TYPE_TRUE: begin
                true_d = 1'b1;
                rle_d  = 1'b0;
              end
              TYPE_GREY: begin
                true_d = 1'b0;
                rle_d  = 1'b0;
              end
              TYPE_RLE_TRUE: begin
                true_d = 1'b1;
                rle_d  = 1'b1;
              end
              TYPE_RLE_GREY: begin
                true_d = 1'b0;
                rle_d  = 1'b1;
              end
              default: begin
                push.push0 = 1'b1;
                push.res0  = err_res(tga_dec_pkg::ERR_TYPE);
                phase_d    = PH_IDLE;
              end
            endcase
          end
          OFF_WIDTH_L:  width_d  = {cur_width[15:8], data_byte_i};
          OFF_WIDTH_H:  width_d  = {data_byte_i, cur_width[7:0]};
          OFF_HEIGHT_L: height_d = {cur_height[15:8], data_byte_i};
          OFF_HEIGHT_H: height_d = {data_byte_i, cur_height[7:0]};
          OFF_DEPTH: begin
            if (data_byte_i != 8'd8 && data_byte_i != 8'd16 &&
                data_byte_i != 8'd24 && data_byte_i != 8'd32) begin
              push.push0 = 1'b1;
              push.res0  = err_res(tga_dec_pkg::ERR_DEPTH);
              phase_d    = PH_IDLE;
            end else begin
              depth_d = data_byte_i[5:0];
            end
          end
          OFF_DESC: begin
            if (data_byte_i[3:0] != 4'd0 && data_byte_i[3:0] != 4'd8) begin
              push.push0 = 1'b1;
              push.res0  = err_res(tga_dec_pkg::ERR_ALPHA);
              phase_d    = PH_IDLE;
            end else begin
              pix_left_d             = area;
              push.push0             = 1'b1;
              push.res0.kind         = tga_dec_pkg::KIND_HEADER;
              push.res0.image_width  = cur_width;
              push.res0.image_height = cur_height;
              push.res0.pixel_bits   = cur_depth;
              push.res0.image_format = !cur_true ? tga_dec_pkg::FMT_GREY :
                                       (cur_depth == 6'd32) ? tga_dec_pkg::FMT_RGBA :
                                       tga_dec_pkg::FMT_RGB;
              push.res0.alpha_bits   = data_byte_i[3:0];
              push.res0.last         = (area == 32'd0);
              if (area == 32'd0) begin
                phase_d = PH_IDLE;
              end else if (cur_id_left != 8'd0) begin
                phase_d = PH_SKIP;
              end else begin
                bip_d      = '0;
                asm_d      = '0;
                pkt_left_d = '0;
                pkt_run_d  = 1'b0;
                phase_d    = cur_rle ? PH_PACKET : PH_PIXEL;
              end
            end
          end
          default: ;
        endcase
      end
      PH_SKIP: begin
        id_left_d = cur_id_left - 8'd1;
        if (cur_id_left == 8'd1) begin
          bip_d      = '0;
          asm_d      = '0;
          pkt_left_d = '0;
          pkt_run_d  = 1'b0;
          phase_d    = cur_rle ? PH_PACKET : PH_PIXEL;
        end
      end
      PH_PACKET: begin
        if (32'(pkt_cnt) > cur_pix_left) begin
          pkt_cnt = cur_pix_left[7:0];
        end
        pkt_left_d = pkt_cnt;
        pkt_run_d  = data_byte_i[7];
        bip_d      = '0;
        asm_d      = '0;
        phase_d    = PH_PIXEL;
      end
      PH_PIXEL: begin
        if (bip_inc >= nbytes) begin
          if (cur_true && (cur_depth == 6'd24 || cur_depth == 6'd32)) begin
            pix_val = {asm_new[31:24], asm_new[7:0], asm_new[15:8], asm_new[23:16]};
          end
          rep = cur_pkt_run ? 32'(cur_pkt_left) : 32'd1;
          if (rep > cur_pix_left) begin
            rep = cur_pix_left;
          end
          pix_rem                = cur_pix_left - rep;
          pix_left_d             = pix_rem;
          push.push0             = 1'b1;
          push.res0.kind         = tga_dec_pkg::KIND_PIXEL;
          push.res0.pixel_value  = pix_val;
          push.res0.repeat_count = rep[7:0];
          push.res0.last         = (pix_rem == 32'd0);
          bip_d                  = '0;
          asm_d                  = '0;
          if (cur_rle) begin
            pkt_next   = cur_pkt_run ? 8'd0 : cur_pkt_left - 8'd1;
            pkt_left_d = pkt_next;
            if (pkt_next == 8'd0) begin
              phase_d = PH_PACKET;
            end
          end
          if (pix_rem == 32'd0) begin
            phase_d = PH_IDLE;
          end
        end else begin
          bip_d = cur_bip + 2'd1;
          asm_d = asm_new;
        end
      end
      default: ;
    endcase

    if (file_end_i && phase_d != PH_IDLE) begin
      phase_d = PH_IDLE;
      if (push.push0) begin
        push.push1 = 1'b1;
        push.res1  = err_res(tga_dec_pkg::ERR_TRUNC);
      end else begin
        push.push0 = 1'b1;
        push.res0  = err_res(tga_dec_pkg::ERR_TRUNC);
      end
    end
  end

  always_comb begin
    push_o       = push;
    push_o.push0 = push.push0 & accept_i;
    push_o.push1 = push.push1 & accept_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q    <= PH_HEADER;
      off_q      <= '0;
      id_left_q  <= '0;
      width_q    <= '0;
      height_q   <= '0;
      depth_q    <= '0;
      rle_q      <= 1'b0;
      true_q     <= 1'b0;
      pix_left_q <= '0;
      pkt_left_q <= '0;
      pkt_run_q  <= 1'b0;
      asm_q      <= '0;
      bip_q      <= '0;
    end else if (accept_i) begin
      phase_q    <= phase_d;
      off_q      <= off_d;
      id_left_q  <= id_left_d;
      width_q    <= width_d;
      height_q   <= height_d;
      depth_q    <= depth_d;
      rle_q      <= rle_d;
      true_q     <= true_d;
      pix_left_q <= pix_left_d;
      pkt_left_q <= pkt_left_d;
      pkt_run_q  <= pkt_run_d;
      asm_q      <= asm_d;
      bip_q      <= bip_d;
    end
  end

endmodule

// ===== hw/rtl/tga_dec_outq.sv =====
// Result queue taking up to two results per beat and giving one per beat.
`timescale 1ns / 1ps
module tga_dec_outq (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  tga_dec_pkg::push_t    push_i,
  output tga_dec_pkg::result_t  head_o,
  output logic                  valid_o,
  input  logic                  ready_i,
  output logic                  room_o
);

  localparam int PtrW = tga_dec_pkg::OUTQ_PTR_W;
  localparam int CntW = tga_dec_pkg::OUTQ_CNT_W;

  tga_dec_pkg::result_t mem_q [tga_dec_pkg::OUTQ_DEPTH];
  logic [PtrW-1:0] wr_q, wr_d, rd_q, rd_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            pop;

  assign valid_o = (cnt_q != '0);
  assign head_o  = mem_q[rd_q];
  assign pop     = valid_o & ready_i;
  assign room_o  = (cnt_q <= CntW'(tga_dec_pkg::OUTQ_DEPTH - 2));

  assign wr_d  = wr_q + PtrW'(push_i.push0) + PtrW'(push_i.push1);
  assign rd_d  = rd_q + PtrW'(pop);
  assign cnt_d = cnt_q + CntW'(push_i.push0) + CntW'(push_i.push1) - CntW'(pop);

  always_ff @(posedge clk_i) begin
    if (push_i.push0) begin
      mem_q[wr_q] <= push_i.res0;
    end
    if (push_i.push1) begin
      mem_q[wr_q + PtrW'(1)] <= push_i.res1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

endmodule

// ===== hw/rtl/tga_image_stream_decoder.sv =====
// Top level of the streaming TGA decoder.
// Usage:
//   in_i carries one file byte per beat with file_start on byte 0 of a file
//   and file_end on its final byte. out_o carries results: one header beat
//   (width, height, depth, format, alpha), then pixel runs (value and repeat
//   count), or an error beat; last marks the final result of an image.
//   A byte yields zero, one or two results; bytes after the end of an image
//   or an error are dropped until the next file_start.
// Output: each result is registered in the result queue as its byte is taken.
// Throughput: one byte per cycle while in_i.ready is high. The parser state
//   updates once per byte; a four-entry result queue decouples the two
//   channels; in_i.ready drops only while the queue holds over two results.
// Reset: parser returns to header byte 0 and the queue empties; the first
//   byte after reset is parsed as a header byte even without file_start.
// Stall: while out_o.ready is low results wait in the queue and input
//   stops once fewer than two free entries remain.
`timescale 1ns / 1ps
module tga_image_stream_decoder (
  input  logic          clk_i,
  input  logic          rst_ni,
  tga_dec_in_if.sink    in_i,
  tga_dec_out_if.source out_o
);

  logic                 accept;
  logic                 room;
  tga_dec_pkg::push_t   push;
  tga_dec_pkg::result_t head;

  assign in_i.ready = room;
  assign accept     = in_i.valid & room;

  tga_dec_parser u_parser (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .accept_i     (accept),
    .data_byte_i  (in_i.data_byte),
    .file_start_i (in_i.file_start),
    .file_end_i   (in_i.file_end),
    .push_o       (push)
  );

  tga_dec_outq u_outq (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .head_o  (head),
    .valid_o (out_o.valid),
    .ready_i (out_o.ready),
    .room_o  (room)
  );

  assign out_o.kind         = head.kind;
  assign out_o.pixel_value  = head.pixel_value;
  assign out_o.repeat_count = head.repeat_count;
  assign out_o.image_width  = head.image_width;
  assign out_o.image_height = head.image_height;
  assign out_o.pixel_bits   = head.pixel_bits;
  assign out_o.image_format = head.image_format;
  assign out_o.alpha_bits   = head.alpha_bits;
  assign out_o.error_code   = head.error_code;
  assign out_o.last         = head.last;

  a_second_after_first: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push.push1 |-> push.push0)
    else $error("second result pushed without first");

  a_push_needs_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push.push0 |-> accept)
    else $error("result pushed without an accepted byte");

  a_error_is_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && out_o.kind == tga_dec_pkg::KIND_ERROR |-> out_o.last)
    else $error("error result without last");

  a_run_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && out_o.kind == tga_dec_pkg::KIND_PIXEL |-> out_o.repeat_count != 8'd0)
    else $error("pixel run with zero count");

endmodule
